// ===== hw/rtl/scsn_pkg.sv =====
// Shared types and constants for the two-channel slew setpoint node.
// No dependencies; used by the top level.
`timescale 1ns / 1ps

package scsn_pkg;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_FRAME = 2'd1,
		CMD_SLOT  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_STEP_LIMIT        = 3'd0,
		REG_PERIOD_FIRST      = 3'd1,
		REG_PERIOD_SECOND     = 3'd2,
		REG_OWN_SOURCE        = 3'd3,
		REG_CONTROLLER_SOURCE = 3'd4,
		REG_GROUP_FIRST       = 3'd5,
		REG_GROUP_SECOND      = 3'd6
	} reg_idx_t;

	localparam logic [15:0] LEVEL_RESET         = 16'h0200;
	localparam logic [15:0] STEP_RESET          = 16'd50;
	localparam logic [15:0] PERIOD_FIRST_RESET  = 16'd1000;
	localparam logic [15:0] PERIOD_SECOND_RESET = 16'd2500;
	localparam logic [31:0] EXT_FLAG            = 32'h8000_0000;

	localparam int FIFO_DEPTH = 4;

	// per-channel record held in RAM
	typedef struct packed {
		logic [15:0] target;
		logic [15:0] position;
		logic [15:0] countdown;
	} chan_rec_t;

	// one report frame
	typedef struct packed {
		logic [31:0] identifier;
		logic [15:0] position;
		logic        channel;
		logic        last;
	} report_t;

endpackage

// ===== hw/rtl/scsn_ram.sv =====
// Generic single-write, single-read RAM with registered read (read-first).
// No dependencies.
`timescale 1ns / 1ps

module scsn_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 2
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/two_channel_slew_setpoint_can_node.sv =====
// Top level of the two-channel slew setpoint node: sequencer, RAM-held
// channel state, report queue and register file. Uses scsn_pkg, scsn_ram.
`timescale 1ns / 1ps

//  channel  | direction | handshake              | word
//  ---------+-----------+------------------------+-----------------------------------------
//  item     | in        | item_valid/item_stall  | command, rx_identifier, rx_value_high/low
//  result   | out       | result_valid/result_stall | tx_identifier, tx_position, tx_channel, last
//  cfg      | in        | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// Sequencing: each word is walked one channel per cycle while the report queue has room,
//   and holds the sequencer until its last channel is read; the single RAM read port sets this.
//   A result goes from the RAM read through the stage 1 registers into the report queue.
// Reset: arst_n clears control state at once; per-channel valid bits make
//   unwritten RAM entries read as the reset record, so no clearing pass.
// Stalls: reports queue in a four-deep FIFO; the sequencer only reads a
//   channel when the queue has room for everything in flight.

module two_channel_slew_setpoint_can_node #(
	parameter int CHANNELS = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	// item channel
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  command,
	input  logic [31:0] rx_identifier,
	input  logic [7:0]  rx_value_high,
	input  logic [7:0]  rx_value_low,
	// result channel
	output logic        result_valid,
	input  logic        result_stall,
	output logic [31:0] tx_identifier,
	output logic [15:0] tx_position,
	output logic        tx_channel,
	output logic        last,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int REC_W   = $bits(scsn_pkg::chan_rec_t);
	localparam int FIFO_AW = $clog2(scsn_pkg::FIFO_DEPTH);
	localparam int CNT_W   = $clog2(scsn_pkg::FIFO_DEPTH + 1);
	localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

	// ------------------------------------------------------------------
	// register file
	// ------------------------------------------------------------------
	logic [15:0] step_limit_q, period_first_q, period_second_q;
	logic [7:0]  own_source_q, ctrl_source_q;
	logic [15:0] group_first_q, group_second_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_limit_q    <= scsn_pkg::STEP_RESET;
			period_first_q  <= scsn_pkg::PERIOD_FIRST_RESET;
			period_second_q <= scsn_pkg::PERIOD_SECOND_RESET;
			own_source_q    <= 8'd0;
			ctrl_source_q   <= 8'd0;
			group_first_q   <= 16'd0;
			group_second_q  <= 16'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (scsn_pkg::reg_idx_t'(cfg_index))
				scsn_pkg::REG_STEP_LIMIT:        step_limit_q    <= cfg_data;
				scsn_pkg::REG_PERIOD_FIRST:      period_first_q  <= cfg_data;
				scsn_pkg::REG_PERIOD_SECOND:     period_second_q <= cfg_data;
				scsn_pkg::REG_OWN_SOURCE:        own_source_q    <= cfg_data[7:0];
				scsn_pkg::REG_CONTROLLER_SOURCE: ctrl_source_q   <= cfg_data[7:0];
				scsn_pkg::REG_GROUP_FIRST:       group_first_q   <= cfg_data;
				scsn_pkg::REG_GROUP_SECOND:      group_second_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// input word register and channel sequencer
	// ------------------------------------------------------------------
	logic                 item_q;
	logic [CH_W-1:0]      chan_q;
	scsn_pkg::cmd_t       cmd_q;
	logic [31:0]          id_q;
	logic [15:0]          val_q;

	logic                 s1_valid;
	logic [CH_W-1:0]      chan_s1;
	scsn_pkg::cmd_t       cmd_s1;
	logic [31:0]          id_s1;
	logic [15:0]          val_s1;

	logic [CNT_W-1:0]     fifo_cnt_q;
	logic [CNT_W:0]       occ;
	logic                 space, issue, done, accept;

	// queue entries plus the report that may come out of stage 1
	assign occ    = {1'b0, fifo_cnt_q} + {{CNT_W{1'b0}}, s1_valid};
	assign space  = occ < (CNT_W + 1)'(scsn_pkg::FIFO_DEPTH);
	assign issue  = item_q && space;
	assign done   = issue && (chan_q == LAST_CH);
	assign item_stall = item_q && !done;
	assign accept = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_q <= 1'b0;
			chan_q <= '0;
		end else if (accept) begin
			item_q <= 1'b1;
			chan_q <= '0;
		end else if (done) begin
			item_q <= 1'b0;
		end else if (issue) begin
			chan_q <= chan_q + CH_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= scsn_pkg::cmd_t'(command);
			id_q  <= rx_identifier;
			val_q <= {rx_value_high, rx_value_low};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else begin
			s1_valid <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			chan_s1 <= chan_q;
			cmd_s1  <= cmd_q;
			id_s1   <= id_q;
			val_s1  <= val_q;
		end
	end

	// ------------------------------------------------------------------
	// channel state RAM, read in the issue cycle, written back in stage 1
	// ------------------------------------------------------------------
	logic                  we;
	scsn_pkg::chan_rec_t   rec, new_rec;
	logic [REC_W-1:0]      rdata;

	logic                  wr_valid_q;
	logic [CH_W-1:0]       wr_addr_q;
	scsn_pkg::chan_rec_t   wr_data_q;
	logic                  valid_q [CHANNELS];
	logic [CHANNELS-1:0]   pend_q;

	scsn_ram #(
		.WIDTH (REC_W),
		.DEPTH (CHANNELS)
	) u_state_ram (
		.clk   (clk),
		.we    (we),
		.waddr (chan_s1),
		.wdata (new_rec),
		.raddr (chan_q),
		.rdata (rdata)
	);

	// the RAM reads old data when written in the read cycle: forward that write
	always_comb begin
		if (wr_valid_q && (wr_addr_q == chan_s1)) begin
			rec = wr_data_q;
		end else if (valid_q[chan_s1]) begin
			rec = scsn_pkg::chan_rec_t'(rdata);
		end else begin
			rec.target    = scsn_pkg::LEVEL_RESET;
			rec.position  = scsn_pkg::LEVEL_RESET;
			rec.countdown = 16'd0;
		end
	end

	// ------------------------------------------------------------------
	// stage 1: per-channel update
	// ------------------------------------------------------------------
	logic [15:0] period, group, cd_dec, diff, mv, slew_pos, rx_grp;
	logic        rising, upd, hit, higher_pend, push, pend_set, pend_clr;
	scsn_pkg::report_t rpt;

	assign period = (chan_s1 == '0) ? period_first_q : period_second_q;
	assign group  = (chan_s1 == '0) ? group_first_q  : group_second_q;

	assign cd_dec   = (rec.countdown != 16'd0) ? rec.countdown - 16'd1 : 16'd0;
	assign rising   = rec.target > rec.position;
	assign diff     = rising ? rec.target - rec.position : rec.position - rec.target;
	assign mv       = (diff < step_limit_q) ? diff : step_limit_q;
	assign slew_pos = rising ? rec.position + mv : rec.position - mv;
	assign upd      = (cd_dec == 16'd0) && !pend_q[chan_s1];

	// group is zero unless some identifier bit below the flags is set
	assign rx_grp = (|id_s1[28:0]) ? id_s1[23:8] : 16'd0;
	assign hit    = (id_s1[7:0] == ctrl_source_q) && (rx_grp == group);

	always_comb begin
		higher_pend = 1'b0;
		for (int k = 0; k < CHANNELS; k++) begin
			if ((CH_W'(k) > chan_s1) && pend_q[k]) begin
				higher_pend = 1'b1;
			end
		end
	end

	always_comb begin
		new_rec  = rec;
		we       = 1'b0;
		push     = 1'b0;
		pend_set = 1'b0;
		pend_clr = 1'b0;
		case (cmd_s1)
			scsn_pkg::CMD_TICK: begin
				we = s1_valid;
				new_rec.countdown = cd_dec;
				if (upd) begin
					new_rec.position  = slew_pos;
					new_rec.countdown = period;
					pend_set = s1_valid;
				end
			end
			scsn_pkg::CMD_FRAME: begin
				if (hit) begin
					we = s1_valid;
					new_rec.target = val_s1;
				end
			end
			scsn_pkg::CMD_SLOT: begin
				if (pend_q[chan_s1]) begin
					push     = s1_valid;
					pend_clr = s1_valid;
				end
			end
			default: ;
		endcase
	end

	assign rpt.identifier = scsn_pkg::EXT_FLAG | {8'd0, group, own_source_q};
	assign rpt.position   = rec.position;
	assign rpt.channel    = chan_s1[0];
	assign rpt.last       = !higher_pend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_valid_q <= 1'b0;
			pend_q     <= '0;
			for (int k = 0; k < CHANNELS; k++) begin
				valid_q[k] <= 1'b0;
			end
		end else begin
			wr_valid_q <= we;
			if (we) begin
				valid_q[chan_s1] <= 1'b1;
			end
			if (pend_set) begin
				pend_q[chan_s1] <= 1'b1;
			end else if (pend_clr) begin
				pend_q[chan_s1] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_q <= chan_s1;
		wr_data_q <= new_rec;
	end

	// ------------------------------------------------------------------
	// report queue
	// ------------------------------------------------------------------
	scsn_pkg::report_t  fifo_mem_q [scsn_pkg::FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic               pop;

	assign result_valid  = fifo_cnt_q != '0;
	assign pop           = result_valid && !result_stall;
	assign tx_identifier = fifo_mem_q[rd_ptr_q].identifier;
	assign tx_position   = fifo_mem_q[rd_ptr_q].position;
	assign tx_channel    = fifo_mem_q[rd_ptr_q].channel;
	assign last          = fifo_mem_q[rd_ptr_q].last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			if (push && !pop) begin
				fifo_cnt_q <= fifo_cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				fifo_cnt_q <= fifo_cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_mem_q[wr_ptr_q] <= rpt;
		end
	end

`ifndef SYNTHESIS
	// the credit check must keep the report queue from overflowing
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (fifo_cnt_q < CNT_W'(scsn_pkg::FIFO_DEPTH)))
		else $error("report queue overflow");

	// a new word always starts its walk at channel zero
	a_walk_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (item_q && (chan_q == '0)))
		else $error("sequencer did not restart at channel zero");

	// the frame flagged last leaves no report pending
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(push && rpt.last) |=> (pend_q == '0))
		else $error("report still pending after last frame");
`endif

endmodule

// ===== test/tb_two_channel_slew_setpoint_can_node.sv =====
// Self-checking testbench for the two-channel slew setpoint node: directed and random
// command words, a built-in predictor of the report frames, and random idling on both sides.
// Depends on scsn_pkg and two_channel_slew_setpoint_can_node, which also needs scsn_ram.
`timescale 1ns / 1ps

module tb_two_channel_slew_setpoint_can_node;

	localparam int CLK_PERIOD   = 12;
	localparam int LIMIT_CYCLES = 500_000;
	localparam int PHASE_WORDS  = 250;

	// one command word as the item channel carries it
	typedef struct packed {
		scsn_pkg::cmd_t cmd;
		logic [31:0]    id;
		logic [7:0]     hi;
		logic [7:0]     lo;
	} word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic [1:0]  command = scsn_pkg::CMD_NONE;
	logic [31:0] rx_identifier = '0;
	logic [7:0]  rx_value_high = '0;
	logic [7:0]  rx_value_low = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [31:0] tx_identifier;
	logic [15:0] tx_position;
	logic        tx_channel;
	logic        last;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	two_channel_slew_setpoint_can_node u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.command       (command),
		.rx_identifier (rx_identifier),
		.rx_value_high (rx_value_high),
		.rx_value_low  (rx_value_low),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.tx_identifier (tx_identifier),
		.tx_position   (tx_position),
		.tx_channel    (tx_channel),
		.last          (last),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		clk = 1'b0;
		#(CLK_PERIOD / 2);
		clk = 1'b1;
		#(CLK_PERIOD / 2);
	end

	// ------------------------------------------------------------------
	// Predictor: a private copy of the register file and channel state.
	// Register copies only change while the node is idle, so the monitor
	// can read them without ordering concerns.
	// ------------------------------------------------------------------
	logic [15:0] step_set;
	logic [15:0] period_set [2];
	logic [7:0]  own_set;
	logic [7:0]  ctrl_set;
	logic [15:0] group_set [2];

	logic [15:0] target_now [2];
	logic [15:0] position_now [2];
	logic        report_owed [2];
	logic [15:0] countdown_now [2];

	scsn_pkg::report_t due_reports [$];
	word_t             word_q [$];

	int                mismatches = 0;
	int                send_odds = 0;
	int                stall_odds = 0;
	int                send_gap = 0;
	int                stall_gap = 0;
	logic              item_fired = 1'b0;
	logic [15:0]       recent_value = scsn_pkg::LEVEL_RESET;
	word_t             offer;
	scsn_pkg::report_t seen;
	scsn_pkg::report_t want;

	// one slew step: move towards the target by no more than the limit
	function automatic logic [15:0] slewed(input logic [15:0] tgt, input logic [15:0] pos,
			input logic [15:0] lim);
		logic [15:0] gap;
		gap = (tgt > pos) ? tgt - pos : pos - tgt;
		if (gap > lim)
			gap = lim;
		return (tgt > pos) ? pos + gap : pos - gap;
	endfunction

	// apply one accepted word to the predicted state; queue the reports it owes
	task automatic advance_node(input scsn_pkg::cmd_t cmd, input logic [31:0] id,
			input logic [7:0] hi, input logic [7:0] lo);
		logic [15:0]       grp;
		int                top;
		scsn_pkg::report_t rep;
		case (cmd)
			scsn_pkg::CMD_TICK: begin
				for (int ch = 0; ch < 2; ch++) begin
					if (countdown_now[ch] != 0)
						countdown_now[ch] = countdown_now[ch] - 16'd1;
					// a channel still owing a report parks at zero until the slot clears it
					if (countdown_now[ch] == 0 && !report_owed[ch]) begin
						position_now[ch]  = slewed(target_now[ch], position_now[ch], step_set);
						report_owed[ch]   = 1'b1;
						countdown_now[ch] = period_set[ch];
					end
				end
			end
			scsn_pkg::CMD_FRAME: begin
				// the group field only counts when some identifier bit below the flags is set
				grp = (id[28:0] != 0) ? id[23:8] : 16'h0000;
				if (id[7:0] == ctrl_set) begin
					for (int ch = 0; ch < 2; ch++)
						if (grp == group_set[ch])
							target_now[ch] = {hi, lo};
				end
			end
			scsn_pkg::CMD_SLOT: begin
				top = -1;
				for (int ch = 0; ch < 2; ch++)
					if (report_owed[ch])
						top = ch;
				for (int ch = 0; ch < 2; ch++) begin
					if (report_owed[ch]) begin
						rep.identifier = scsn_pkg::EXT_FLAG | {8'h00, group_set[ch], own_set};
						rep.position   = position_now[ch];
						rep.channel    = ch[0];
						rep.last       = (ch == top);
						due_reports.push_back(rep);
						report_owed[ch] = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Driver: offers queued words on the falling edge, holds a stalled word
	// steady, and inserts idle bursts of random length when asked to.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (item_valid && !item_fired) begin
			// word still on offer: leave it untouched
		end else if (send_gap != 0) begin
			item_valid <= 1'b0;
			send_gap   <= send_gap - 1;
		end else if (word_q.size() != 0 && send_odds != 0
				&& $urandom_range(1, send_odds) == 1) begin
			item_valid <= 1'b0;
			send_gap   <= $urandom_range(0, 13);
		end else if (word_q.size() != 0) begin
			offer = word_q.pop_front();
			item_valid    <= 1'b1;
			command       <= offer.cmd;
			rx_identifier <= offer.id;
			rx_value_high <= offer.hi;
			rx_value_low  <= offer.lo;
		end else begin
			item_valid <= 1'b0;
		end
	end

	// receiver back-pressure, in random bursts drawn like the driver's idle bursts
	always @(negedge clk) begin
		if (stall_gap != 0) begin
			result_stall <= 1'b1;
			stall_gap    <= stall_gap - 1;
		end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
			result_stall <= 1'b1;
			stall_gap    <= $urandom_range(0, 13);
		end else begin
			result_stall <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: on the rising edge, feed accepted words to the predictor and
	// compare each accepted report with the oldest one due.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		item_fired <= item_valid && !item_stall;
		if (arst_n && item_valid && !item_stall)
			advance_node(scsn_pkg::cmd_t'(command), rx_identifier, rx_value_high,
				rx_value_low);
		if (arst_n && result_valid && !result_stall) begin
			seen = {tx_identifier, tx_position, tx_channel, last};
			if (due_reports.size() == 0) begin
				mismatches++;
				$display("%0t: report with none due: expected none, %s", $time,
					$sformatf("got id %h pos %h ch %0d last %0d", seen.identifier,
						seen.position, seen.channel, seen.last));
			end else begin
				want = due_reports.pop_front();
				if (seen !== want) begin
					mismatches++;
					$display("%0t: report mismatch: expected id %h pos %h ch %0d last %0d, %s",
						$time, want.identifier, want.position, want.channel, want.last,
						$sformatf("got id %h pos %h ch %0d last %0d", seen.identifier,
							seen.position, seen.channel, seen.last));
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic add_word(input scsn_pkg::cmd_t cmd, input logic [31:0] id,
			input logic [15:0] val);
		word_q.push_back({cmd, id, val});
	endtask

	// register write; the copy is updated at the edge that takes it
	task automatic write_reg(input scsn_pkg::reg_idx_t idx, input logic [15:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			scsn_pkg::REG_STEP_LIMIT:        step_set = data;
			scsn_pkg::REG_PERIOD_FIRST:      period_set[0] = data;
			scsn_pkg::REG_PERIOD_SECOND:     period_set[1] = data;
			scsn_pkg::REG_OWN_SOURCE:        own_set = data[7:0];
			scsn_pkg::REG_CONTROLLER_SOURCE: ctrl_set = data[7:0];
			scsn_pkg::REG_GROUP_FIRST:       group_set[0] = data;
			scsn_pkg::REG_GROUP_SECOND:      group_set[1] = data;
			default: begin
			end
		endcase
	endtask

	task automatic load_setting(input logic [15:0] step, input logic [15:0] pf,
			input logic [15:0] ps, input logic [7:0] own, input logic [7:0] ctrl,
			input logic [15:0] gf, input logic [15:0] gs);
		write_reg(scsn_pkg::REG_STEP_LIMIT, step);
		write_reg(scsn_pkg::REG_PERIOD_FIRST, pf);
		write_reg(scsn_pkg::REG_PERIOD_SECOND, ps);
		write_reg(scsn_pkg::REG_OWN_SOURCE, {8'h00, own});
		write_reg(scsn_pkg::REG_CONTROLLER_SOURCE, {8'h00, ctrl});
		write_reg(scsn_pkg::REG_GROUP_FIRST, gf);
		write_reg(scsn_pkg::REG_GROUP_SECOND, gs);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// sender holds off until the queue is empty, every report has come and the
	// node has had time to finish a word that owes nothing
	task automatic settle;
		@(posedge clk);
		while (word_q.size() != 0 || item_valid || due_reports.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// random word: mostly ticks, slots and well-formed commands to our groups
	function automatic word_t random_word();
		word_t       w;
		int          pick;
		logic [15:0] val;
		pick = $urandom_range(0, 99);
		w.id = $urandom;
		w.hi = 8'($urandom);
		w.lo = 8'($urandom);
		if (pick < 35) begin
			w.cmd = scsn_pkg::CMD_TICK;
		end else if (pick < 65) begin
			w.cmd = scsn_pkg::CMD_SLOT;
		end else if (pick < 96) begin
			w.cmd = scsn_pkg::CMD_FRAME;
			if ($urandom_range(0, 3) != 0) begin
				w.id[31]   = 1'b1;
				w.id[7:0]  = ctrl_set;
				pick       = $urandom_range(0, 9);
				w.id[23:8] = (pick < 5) ? group_set[0] : (pick < 9) ? group_set[1] : w.id[23:8];
			end else if ($urandom_range(0, 1) == 1) begin
				w.id[7:0] = ctrl_set;
			end
			// extremes, small moves near the last command, or anything
			case ($urandom_range(0, 7))
				0:       val = 16'h0000;
				1:       val = 16'hffff;
				2, 3:    val = recent_value + 16'($urandom_range(0, 200)) - 16'd100;
				default: val = 16'($urandom);
			endcase
			recent_value = val;
			{w.hi, w.lo} = val;
		end else begin
			w.cmd = scsn_pkg::CMD_NONE;
		end
		return w;
	endfunction

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		word_t       w;
		int          counted;
		logic [15:0] g;
		logic [15:0] step;

		step_set     = scsn_pkg::STEP_RESET;
		period_set   = '{scsn_pkg::PERIOD_FIRST_RESET, scsn_pkg::PERIOD_SECOND_RESET};
		own_set      = 8'h00;
		ctrl_set     = 8'h00;
		group_set    = '{16'h0000, 16'h0000};
		target_now   = '{scsn_pkg::LEVEL_RESET, scsn_pkg::LEVEL_RESET};
		position_now = '{scsn_pkg::LEVEL_RESET, scsn_pkg::LEVEL_RESET};
		report_owed  = '{1'b0, 1'b0};
		countdown_now = '{16'h0000, 16'h0000};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// directed, reset registers; no tick yet so the long reset periods never load
		send_odds  = 4;
		stall_odds = 4;
		add_word(scsn_pkg::CMD_SLOT, $urandom, 16'($urandom));  // nothing pending: silent
		add_word(scsn_pkg::CMD_NONE, $urandom, 16'($urandom));  // unused code: ignored
		add_word(scsn_pkg::CMD_FRAME, 32'h8000_0000, 16'h1234); // no low bits set: group 0
		add_word(scsn_pkg::CMD_FRAME, 32'h2000_0000, 16'h0000); // both channels share group 0
		add_word(scsn_pkg::CMD_FRAME, 32'hffff_ff01, 16'hffff); // foreign source: dropped
		settle();

		// zero step, zero period on channel zero
		load_setting(16'h0000, 16'h0000, 16'h0001, 8'hff, 8'hff, 16'hffff, 16'h0000);
		add_word(scsn_pkg::CMD_TICK, $urandom, 16'($urandom));  // first tick updates both
		add_word(scsn_pkg::CMD_TICK, $urandom, 16'($urandom));  // both parked: report owed
		add_word(scsn_pkg::CMD_SLOT, $urandom, 16'($urandom));
		add_word(scsn_pkg::CMD_TICK, $urandom, 16'($urandom));
		add_word(scsn_pkg::CMD_SLOT, $urandom, 16'($urandom));
		add_word(scsn_pkg::CMD_TICK, $urandom, 16'($urandom));
		settle();

		// full-range step: positions jump straight to the extremes
		load_setting(16'hffff, 16'h0001, 16'h0001, 8'h00, 8'h00, 16'h0001, 16'hffff);
		add_word(scsn_pkg::CMD_FRAME, 32'h9fff_ff00, 16'hffff);
		add_word(scsn_pkg::CMD_FRAME, 32'h0000_0100, 16'h0000); // flag clear, still matched
		add_word(scsn_pkg::CMD_SLOT, $urandom, 16'($urandom));
		add_word(scsn_pkg::CMD_TICK, $urandom, 16'($urandom));
		add_word(scsn_pkg::CMD_SLOT, $urandom, 16'($urandom));
		add_word(scsn_pkg::CMD_TICK, $urandom, 16'($urandom));
		add_word(scsn_pkg::CMD_SLOT, $urandom, 16'($urandom));
		settle();

		// random phases, a fresh register setting each; the last runs with no idling
		// and leaves channel one on the longest period, so it comes last of all
		for (int phase = 0; phase < 6; phase++) begin
			g = 16'($urandom);
			case (phase)
				0: load_setting(16'd1, 16'd1, 16'd2, 8'h00, 8'hff, 16'h0000, 16'hffff);
				1: load_setting(16'hffff, 16'd2, 16'd1, 8'hff, 8'h00, g, g);
				5: load_setting(16'($urandom_range(1, 5000)), 16'd1, 16'hffff, 8'($urandom),
					8'($urandom), 16'($urandom), 16'($urandom));
				default: begin
					case ($urandom_range(0, 3))
						0:       step = 16'h0000;
						1:       step = 16'hffff;
						2:       step = 16'($urandom_range(1, 200));
						default: step = 16'($urandom);
					endcase
					load_setting(step, 16'($urandom_range(0, 5)), 16'($urandom_range(0, 5)),
						8'($urandom), 8'($urandom), g,
						($urandom_range(0, 3) == 0) ? g : 16'($urandom));
				end
			endcase
			send_odds  = (phase == 5) ? 0 : $urandom_range(2, 20);
			stall_odds = (phase == 5) ? 0 : $urandom_range(2, 20);
			counted = 0;
			while (counted < PHASE_WORDS) begin
				w = random_word();
				word_q.push_back(w);
				if (w.cmd != scsn_pkg::CMD_NONE)
					counted++;
			end
			settle();
		end

		if (mismatches == 0)
			$display("PASS two_channel_slew_setpoint_can_node");
		else
			$display("FAIL two_channel_slew_setpoint_can_node");
		$finish;
	end

	// hard stop should the node hang
	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("FAIL two_channel_slew_setpoint_can_node");
		$finish;
	end

endmodule
